FILE: hdl/stereo_ping_pong_delay_macros.svh
// Assertion helpers, clocked on clk and held off while rst_n is low.
`ifndef STEREO_PING_PONG_DELAY_MACROS_SVH
`define STEREO_PING_PONG_DELAY_MACROS_SVH

// cons must hold in the same cycle as ante
`define SPPD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// cons must hold in the cycle after ante
`define SPPD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/sppd_pkg.sv
package sppd_pkg;

  localparam int MAX_DELAY_DEF   = 16384;
  localparam int SAMPLE_BITS_DEF = 24;

  localparam int DELAY_LEN_W     = 15;
  localparam int GAIN_W          = 16;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 16;

  localparam logic [DELAY_LEN_W-1:0] DELAY_LEN_RST = 15'd16000;
  localparam logic [GAIN_W-1:0]      GAIN_RST      = 16'd16384;

  // gain is unsigned Q2.14, product rounded half up
  localparam int GAIN_FRAC = 14;
  localparam int GAIN_RND  = 8192;

  // 0.6 as 19661 / 2^15, rounded half up
  localparam logic signed [15:0] SIX_TENTHS = 16'sd19661;
  localparam int ECHO_FRAC = 15;
  localparam int ECHO_RND  = 16384;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DELAY_LEN = 2'd0,
    REG_GAIN      = 2'd1
  } cfg_reg_t;

endpackage

FILE: hdl/stereo_ping_pong_delay.sv
// Stereo ping-pong echo. One stereo word in, one stereo word out. Each output is
// (dry + stored echo) * gain (unsigned Q2.14), rounded and saturated; the left
// echo store takes 0.6 * (mono + old right echo), the right store 0.6 * old left
// echo, at a position that wraps at delay_len. The echo stores are two
// single-port-write, registered-read RAMs of MAX_DELAY words; a fill count stands
// in for clearing them, so the block takes words right after reset. A word is
// read at acceptance, passes an add stage, a multiply stage and a round/saturate
// stage, and is written back and shown on the output as it leaves the last
// stage. Throughput is one word per cycle while the output is taken, for delay
// lengths of four or more; a word whose position is still being worked on by an
// earlier word waits until that word has written back, so shorter delays accept
// words less often. The output register lets input words keep flowing into
// empty stages while a result waits to be taken.
// Configuration is taken at once and must only be written while idle.
`include "stereo_ping_pong_delay_macros.svh"
module stereo_ping_pong_delay
  import sppd_pkg::*;
#(
  parameter int MAX_DELAY   = MAX_DELAY_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] in_left_in,
  input  logic signed [SAMPLE_BITS-1:0] in_right_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] out_left_out,
  output logic signed [SAMPLE_BITS-1:0] out_right_out,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data
);

  localparam int AW  = $clog2(MAX_DELAY);
  localparam int CW  = AW + 1;
  localparam int SW  = SAMPLE_BITS;
  localparam int SW1 = SW + 1;
  localparam int EW  = SW + 17;
  localparam int PW  = SW + 18;

  // ---------------- config
  logic [DELAY_LEN_W-1:0] delay_len_r;
  logic [GAIN_W-1:0]      gain_r;

  // ---------------- position / fill
  logic [AW-1:0] pos_r;
  logic [CW-1:0] fill_r;
  logic [31:0]   dl32;
  logic [31:0]   len32;
  logic [CW-1:0] len_eff;
  logic [AW-1:0] rd_addr;
  logic [CW-1:0] pos_inc;
  logic [AW-1:0] pos_nxt;

  // ---------------- echo RAMs
  logic [SW-1:0] mem_l [MAX_DELAY];
  logic [SW-1:0] mem_r [MAX_DELAY];
  logic [SW-1:0] rd_l_r;
  logic [SW-1:0] rd_r_r;

  // ---------------- stages
  logic                  s1_v_r, s2_v_r, s3_v_r, out_valid_r;
  logic                  s1_hit_r;
  logic [AW-1:0]         s1_addr_r, s2_addr_r, s3_addr_r;
  logic signed [SW-1:0]  s1_l_r, s1_r_r;
  logic signed [SW1-1:0] s2_sum_l_r, s2_sum_r_r, s2_eil_r, s2_eir_r;
  logic signed [PW-1:0]  s3_pol_r, s3_por_r;
  logic signed [EW-1:0]  s3_pel_r, s3_per_r;
  logic [SW-1:0]         out_l_r, out_r_r;

  logic signed [SW-1:0]  s1_le, s1_re;
  logic signed [SW1-1:0] s1_sum_lr, s1_mono, s1_sum_l, s1_sum_r, s1_eil, s1_eir;
  logic signed [PW-1:0]  s2_pol, s2_por;
  logic signed [EW-1:0]  s2_pel, s2_per;
  logic signed [PW-1:0]  s3_vol, s3_vor, s3_vel, s3_ver;
  logic [SW-1:0]         out_l_nxt, out_r_nxt, echo_l_nxt, echo_r_nxt;

  logic hazard, in_acc, adv_out, en3, adv2, en2, adv1, en1;

  function automatic logic [SW-1:0] sat_fn(input logic signed [PW-1:0] v);
    logic [PW-SW:0] top;
    top = v[PW-1:SW-1];
    if (&top || !(|top)) return v[SW-1:0];
    else if (v[PW-1]) return {1'b1, {(SW-1){1'b0}}};
    else return {1'b0, {(SW-1){1'b1}}};
  endfunction

  // ---------------- position
  assign dl32    = 32'(delay_len_r);
  assign len32   = (dl32 == 32'd0) ? 32'd1 :
                   (dl32 > 32'(MAX_DELAY)) ? 32'(MAX_DELAY) : dl32;
  assign len_eff = len32[CW-1:0];
  assign rd_addr = ({1'b0, pos_r} >= len_eff) ? '0 : pos_r;
  assign pos_inc = {1'b0, rd_addr} + CW'(1);
  assign pos_nxt = (pos_inc >= len_eff) ? '0 : pos_inc[AW-1:0];

  // ---------------- flow control
  // a word may not read a position that an earlier word has yet to write back
  assign hazard  = (s1_v_r && (s1_addr_r == rd_addr)) ||
                   (s2_v_r && (s2_addr_r == rd_addr)) ||
                   (s3_v_r && (s3_addr_r == rd_addr));
  assign adv_out = s3_v_r && (!out_valid_r || out_ready);
  assign en3     = !s3_v_r || adv_out;
  assign adv2    = s2_v_r && en3;
  assign en2     = !s2_v_r || adv2;
  assign adv1    = s1_v_r && en2;
  assign en1     = !s1_v_r || adv1;
  assign in_ready = en1 && !hazard;
  assign in_acc   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // ---------------- stage 1: echo lookup, sums
  assign s1_le     = s1_hit_r ? $signed(rd_l_r) : '0;
  assign s1_re     = s1_hit_r ? $signed(rd_r_r) : '0;
  assign s1_sum_lr = SW1'(s1_l_r) + SW1'(s1_r_r);
  assign s1_mono   = s1_sum_lr >>> 1;
  assign s1_sum_l  = SW1'(s1_l_r) + SW1'(s1_le);
  assign s1_sum_r  = SW1'(s1_r_r) + SW1'(s1_re);
  assign s1_eil    = s1_mono + SW1'(s1_re);
  assign s1_eir    = SW1'(s1_le);

  // ---------------- stage 2: products
  assign s2_pol = s2_sum_l_r * $signed({1'b0, gain_r});
  assign s2_por = s2_sum_r_r * $signed({1'b0, gain_r});
  assign s2_pel = s2_eil_r * SIX_TENTHS;
  assign s2_per = s2_eir_r * SIX_TENTHS;

  // ---------------- stage 3: round, saturate
  assign s3_vol = (s3_pol_r + PW'(GAIN_RND)) >>> GAIN_FRAC;
  assign s3_vor = (s3_por_r + PW'(GAIN_RND)) >>> GAIN_FRAC;
  assign s3_vel = (PW'(s3_pel_r) + PW'(ECHO_RND)) >>> ECHO_FRAC;
  assign s3_ver = (PW'(s3_per_r) + PW'(ECHO_RND)) >>> ECHO_FRAC;
  assign out_l_nxt  = sat_fn(s3_vol);
  assign out_r_nxt  = sat_fn(s3_vor);
  assign echo_l_nxt = sat_fn(s3_vel);
  assign echo_r_nxt = sat_fn(s3_ver);

  // ---------------- control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_len_r <= DELAY_LEN_RST;
      gain_r      <= GAIN_RST;
      pos_r       <= '0;
      fill_r      <= '0;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_DELAY_LEN: delay_len_r <= cfg_data[DELAY_LEN_W-1:0];
          REG_GAIN:      gain_r      <= cfg_data[GAIN_W-1:0];
          default: ;
        endcase
      end
      if (in_acc) pos_r <= pos_nxt;
      // writes walk up from zero, so the written entries are always a prefix
      if (adv_out && ({1'b0, s3_addr_r} == fill_r)) fill_r <= fill_r + CW'(1);
      if (en1) s1_v_r <= in_acc;
      if (en2) s2_v_r <= adv1;
      if (en3) s3_v_r <= adv2;
      if (adv_out) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // ---------------- payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_addr_r <= rd_addr;
      s1_hit_r  <= ({1'b0, rd_addr} < fill_r);
      s1_l_r    <= in_left_in;
      s1_r_r    <= in_right_in;
    end
    if (adv1) begin
      s2_addr_r  <= s1_addr_r;
      s2_sum_l_r <= s1_sum_l;
      s2_sum_r_r <= s1_sum_r;
      s2_eil_r   <= s1_eil;
      s2_eir_r   <= s1_eir;
    end
    if (adv2) begin
      s3_addr_r <= s2_addr_r;
      s3_pol_r  <= s2_pol;
      s3_por_r  <= s2_por;
      s3_pel_r  <= s2_pel;
      s3_per_r  <= s2_per;
    end
    if (adv_out) begin
      out_l_r <= out_l_nxt;
      out_r_r <= out_r_nxt;
    end
  end

  // ---------------- echo RAMs
  always_ff @(posedge clk) begin
    if (adv_out) begin
      mem_l[s3_addr_r] <= echo_l_nxt;
      mem_r[s3_addr_r] <= echo_r_nxt;
    end
    if (in_acc) begin
      rd_l_r <= mem_l[rd_addr];
      rd_r_r <= mem_r[rd_addr];
    end
  end

  assign out_valid     = out_valid_r;
  assign out_left_out  = $signed(out_l_r);
  assign out_right_out = $signed(out_r_r);

  // ---------------- assertions
  `SPPD_ASSERT_NOW(a_distinct_inflight, s2_v_r && (s1_v_r || s3_v_r), (!s1_v_r || (s1_addr_r != s2_addr_r)) && (!s3_v_r || (s3_addr_r != s2_addr_r)) && (!(s1_v_r && s3_v_r) || (s1_addr_r != s3_addr_r)), "two words in flight share an echo position")
  `SPPD_ASSERT_NOW(a_write_in_prefix, adv_out, {1'b0, s3_addr_r} <= fill_r, "echo write skips past the fill count")
  `SPPD_ASSERT_NEXT(a_pos_in_range, in_acc, {1'b0, pos_r} < $past(len_eff), "position left the delay range")

endmodule
